### hw/rtl/swo_pkg.sv
// Shared types, constants and sine ROM for the stereo wavetable oscillator.
package swo_pkg;

	localparam int TABLE_SIZE    = 512;
	localparam int FRACTION_BITS = 16;
	localparam int INDEX_W       = $clog2(TABLE_SIZE);
	localparam int PHASE_W       = INDEX_W + FRACTION_BITS;
	localparam int PAIR_W        = 2 * PHASE_W;

	localparam int STEP_W   = 25;
	localparam int LEVEL_W  = 7;
	localparam int SAMPLE_W = 16;
	localparam int WAVE_W   = 2;
	localparam int CFG_W    = 25;
	localparam int CFG_IDX_W = 3;

	// level / 128, truncated toward zero
	localparam int SCALE_SHIFT = 7;
	localparam int SCALE_BIAS  = (1 << SCALE_SHIFT) - 1;
	localparam int PROD_W      = SAMPLE_W + LEVEL_W;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	localparam int TRI_STEP   = 131072 / TABLE_SIZE;
	localparam int TRI_OFFSET = TRI_STEP / 2 - 32768;
	localparam int SAW_STEP   = 65536 / TABLE_SIZE;
	localparam int SAW_OFFSET = SAW_STEP / 2 - 32768;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(310062);

	// quarter-wave sine table, QUARTER + 1 entries
	localparam int QUARTER   = TABLE_SIZE / 4;
	localparam int QUARTER_W = $clog2(QUARTER);
	localparam int SINE_W    = SAMPLE_W - 1;
	localparam int SINE_PEAK = 32767;
	localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

	typedef enum logic [WAVE_W-1:0] {
		WAVE_TRIANGLE = 2'd0,
		WAVE_SAW      = 2'd1,
		WAVE_PULSE    = 2'd2,
		WAVE_SINE     = 2'd3
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_WAVEFORM  = 3'd0,
		REG_RIGHT_WAVEFORM = 3'd1,
		REG_LEFT_STEP      = 3'd2,
		REG_RIGHT_STEP     = 3'd3,
		REG_LEFT_LEVEL     = 3'd4,
		REG_RIGHT_LEVEL    = 3'd5
	} reg_idx_t;

	typedef logic [SINE_W-1:0] sine_rom_t [QUARTER+1];

	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// floor(n / d) by long division; only used while the sine table is built
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// trunc(32767 * sin(pi/2 * r / TABLE_SIZE)), Taylor series in Q62
	function automatic logic [SINE_W-1:0] sine_quarter(int unsigned r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] a;
		logic [63:0] b;
		x = (PI_HALF_Q62 / TABLE_SIZE) * 64'(r)
			+ ((PI_HALF_Q62 % TABLE_SIZE) * 64'(r)) / TABLE_SIZE;
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		for (int k = 1; k <= 12; k++) begin
			term = udiv64(mul_q62(term, x2), 64'(2 * k) * 64'(2 * k + 1));
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		a = (sum >> 31) * 64'd32767;
		b = ((sum & 64'h7FFF_FFFF) * 64'd32767) >> 31;
		return SINE_W'((a + b) >> 31);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int j = 0; j <= QUARTER; j++) begin
			if (j == 0)
				rom[j] = '0;
			else if (j == QUARTER)
				rom[j] = SINE_W'(SINE_PEAK);
			else
				rom[j] = sine_quarter(4 * j);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### hw/rtl/swo_if.sv
// Handshake channels of the oscillator: tick requests in, stereo samples out.
interface swo_tick_if;
	logic valid;
	logic ready;
	logic sample_tick;

	modport source (output valid, output sample_tick, input ready);
	modport sink (input valid, input sample_tick, output ready);
endinterface

interface swo_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [swo_pkg::SAMPLE_W-1:0]  left_sample;
	logic signed [swo_pkg::SAMPLE_W-1:0]  right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

### hw/rtl/stereo_wavetable_oscillator.sv
// Top level: two-channel DDS oscillator around a phase RAM with read-modify-write.
//
//  channel   dir   payload                        handshake
//  ticks     in    sample_tick                    valid / ready
//  samples   out   left_sample, right_sample      valid / ready
//  cfg       in    cfg_index, cfg_data            cfg_we, no back-pressure
//
// One item per cycle unless the output stalls; a tick goes through s1, s2, s3 to the output.
// The rate is set by the phase RAM loop: read at accept, add and write back as s1 moves on,
// with a forward of the word just written when the next read overlaps that write.
// Reset clears control state and a phase-valid flag; no RAM clearing pass is needed.
// Output stalls back up stage by stage; ticks are still taken until the pipeline is full.
// A tick of zero is taken and dropped without touching the phases.
module stereo_wavetable_oscillator (
	input  logic                               clk,
	input  logic                               arst_n,
	swo_tick_if.sink                           ticks,
	swo_sample_if.source                       samples,
	input  logic                               cfg_we,
	input  logic [swo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swo_pkg::CFG_W-1:0]          cfg_data
);

	localparam int PW = swo_pkg::PHASE_W;

	swo_pkg::wave_t                      left_wave_q;
	swo_pkg::wave_t                      right_wave_q;
	logic [swo_pkg::STEP_W-1:0]          left_step_q;
	logic [swo_pkg::STEP_W-1:0]          right_step_q;
	logic [swo_pkg::LEVEL_W-1:0]         left_level_q;
	logic [swo_pkg::LEVEL_W-1:0]         right_level_q;

	logic                                en1, en2, en3, en_out;
	logic                                tick_acc;
	logic                                ram_re, ram_we;
	logic [swo_pkg::PAIR_W-1:0]          ram_rdata;
	logic [swo_pkg::PAIR_W-1:0]          phase_old, phase_new, phase_fwd_q;
	logic                                phase_valid_q;

	logic                                valid_s1, fwd_use_s1;
	logic                                valid_s2, valid_s3, out_valid_q;
	logic [swo_pkg::INDEX_W-1:0]         left_idx_s2, right_idx_s2;
	logic signed [swo_pkg::PROD_W-1:0]   left_prod, right_prod;
	logic signed [swo_pkg::PROD_W-1:0]   left_prod_s3, right_prod_s3;
	logic signed [swo_pkg::PROD_W-1:0]   left_biased, right_biased;
	logic signed [swo_pkg::SAMPLE_W-1:0] left_q, right_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_wave_q   <= swo_pkg::WAVE_TRIANGLE;
			right_wave_q  <= swo_pkg::WAVE_TRIANGLE;
			left_step_q   <= swo_pkg::STEP_RESET;
			right_step_q  <= swo_pkg::STEP_RESET;
			left_level_q  <= '0;
			right_level_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swo_pkg::REG_LEFT_WAVEFORM:
					left_wave_q <= swo_pkg::wave_t'(cfg_data[swo_pkg::WAVE_W-1:0]);
				swo_pkg::REG_RIGHT_WAVEFORM:
					right_wave_q <= swo_pkg::wave_t'(cfg_data[swo_pkg::WAVE_W-1:0]);
				swo_pkg::REG_LEFT_STEP:      left_step_q   <= cfg_data[swo_pkg::STEP_W-1:0];
				swo_pkg::REG_RIGHT_STEP:     right_step_q  <= cfg_data[swo_pkg::STEP_W-1:0];
				swo_pkg::REG_LEFT_LEVEL:     left_level_q  <= cfg_data[swo_pkg::LEVEL_W-1:0];
				swo_pkg::REG_RIGHT_LEVEL:    right_level_q <= cfg_data[swo_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, each stage moves when the next one is empty or moving
	assign en_out = !out_valid_q || samples.ready;
	assign en3    = !valid_s3 || en_out;
	assign en2    = !valid_s2 || en3;
	assign en1    = !valid_s1 || en2;

	assign ticks.ready = en1;
	assign tick_acc    = ticks.valid && en1;
	assign ram_re      = tick_acc && ticks.sample_tick;
	assign ram_we      = valid_s1 && en2;

	// one RAM word holds both phases: right in the upper half
	swo_ram #(
		.WIDTH (swo_pkg::PAIR_W),
		.DEPTH (1)
	) u_phase_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (1'b0),
		.wdata (phase_new),
		.re    (ram_re),
		.raddr (1'b0),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (fwd_use_s1)
			phase_old = phase_fwd_q;
		else if (phase_valid_q)
			phase_old = ram_rdata;
		else
			phase_old = '0;
	end

	// the accumulator wraps at TABLE_SIZE << FRACTION_BITS, i.e. at its own width
	assign phase_new = {PW'(phase_old[2*PW-1:PW] + right_step_q),
		PW'(phase_old[PW-1:0] + left_step_q)};

	swo_shaper u_left_shaper (
		.shape   (left_wave_q),
		.idx     (left_idx_s2),
		.level   (left_level_q),
		.product (left_prod)
	);

	swo_shaper u_right_shaper (
		.shape   (right_wave_q),
		.idx     (right_idx_s2),
		.level   (right_level_q),
		.product (right_prod)
	);

	// divide by 128 toward zero: bias negative products before the shift
	assign left_biased  = left_prod_s3
		+ (left_prod_s3[swo_pkg::PROD_W-1] ? swo_pkg::PROD_W'(swo_pkg::SCALE_BIAS) : '0);
	assign right_biased = right_prod_s3
		+ (right_prod_s3[swo_pkg::PROD_W-1] ? swo_pkg::PROD_W'(swo_pkg::SCALE_BIAS) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			fwd_use_s1    <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			out_valid_q   <= 1'b0;
			phase_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1   <= ram_re;
				fwd_use_s1 <= ram_we;
			end
			if (en2)
				valid_s2 <= valid_s1;
			if (en3)
				valid_s3 <= valid_s2;
			if (en_out)
				out_valid_q <= valid_s3;
			if (ram_we)
				phase_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			phase_fwd_q  <= phase_new;
			left_idx_s2  <= phase_new[PW-1 -: swo_pkg::INDEX_W];
			right_idx_s2 <= phase_new[2*PW-1 -: swo_pkg::INDEX_W];
		end
		if (en3 && valid_s2) begin
			left_prod_s3  <= left_prod;
			right_prod_s3 <= right_prod;
		end
		if (en_out && valid_s3) begin
			left_q  <= left_biased[swo_pkg::SCALE_SHIFT +: swo_pkg::SAMPLE_W];
			right_q <= right_biased[swo_pkg::SCALE_SHIFT +: swo_pkg::SAMPLE_W];
		end
	end

	assign samples.valid        = out_valid_q;
	assign samples.left_sample  = left_q;
	assign samples.right_sample = right_q;

	// once a phase word is written it stays the live copy
	a_phase_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid_q |=> phase_valid_q)
		else $error("phase valid flag dropped");

	// forwarding is only chosen after a write has happened
	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_use_s1 |-> phase_valid_q)
		else $error("forward selected with no prior phase write");

	// a stalled read-modify-write keeps its RAM read data
	a_rdata_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en2 |=> $stable(ram_rdata))
		else $error("phase RAM read data changed under a stalled item");

	// ticks are only refused while every pipeline stage is occupied
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!ticks.ready |-> valid_s1 && valid_s2 && valid_s3 && out_valid_q)
		else $error("tick refused with room in the pipeline");

endmodule

### hw/rtl/swo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first: a read and a write in the same cycle return the old word
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/swo_shaper.sv
// Wave sample from table index and shape, times channel level.
module swo_shaper (
	input  swo_pkg::wave_t                        shape,
	input  logic [swo_pkg::INDEX_W-1:0]           idx,
	input  logic [swo_pkg::LEVEL_W-1:0]           level,
	output logic signed [swo_pkg::PROD_W-1:0]     product
);

	logic                                   upper_half;
	logic [1:0]                             quadrant;
	logic [swo_pkg::QUARTER_W-1:0]          quad_pos;
	logic [swo_pkg::QUARTER_W:0]            rom_idx;
	logic [swo_pkg::SINE_W-1:0]             sine_mag;
	logic [swo_pkg::SAMPLE_W-1:0]           tri_rise;
	logic [swo_pkg::SAMPLE_W-1:0]           tri_fall;
	logic [swo_pkg::SAMPLE_W-1:0]           saw_val;
	logic signed [swo_pkg::SAMPLE_W-1:0]    wave;

	assign upper_half = idx[swo_pkg::INDEX_W-1];
	assign quadrant   = idx[swo_pkg::INDEX_W-1 -: 2];
	assign quad_pos   = idx[swo_pkg::QUARTER_W-1:0];

	// odd quadrants run the quarter table backwards
	assign rom_idx = quadrant[0]
		? (swo_pkg::QUARTER_W + 1)'(swo_pkg::QUARTER) - {1'b0, quad_pos}
		: {1'b0, quad_pos};
	assign sine_mag = swo_pkg::SINE_ROM[rom_idx];

	assign tri_rise = swo_pkg::SAMPLE_W'(swo_pkg::TRI_OFFSET + int'(idx) * swo_pkg::TRI_STEP);
	assign tri_fall = swo_pkg::SAMPLE_W'(-swo_pkg::TRI_OFFSET - int'(idx) * swo_pkg::TRI_STEP);
	assign saw_val  = swo_pkg::SAMPLE_W'(swo_pkg::SAW_OFFSET + int'(idx) * swo_pkg::SAW_STEP);

	always_comb begin
		unique case (shape)
			swo_pkg::WAVE_SAW:   wave = $signed(saw_val);
			swo_pkg::WAVE_PULSE: wave = upper_half ? swo_pkg::SAMPLE_W'(swo_pkg::SAMPLE_MIN)
				: swo_pkg::SAMPLE_W'(swo_pkg::SAMPLE_MAX);
			swo_pkg::WAVE_SINE:  wave = upper_half ? -$signed({1'b0, sine_mag})
				: $signed({1'b0, sine_mag});
			default:             wave = upper_half ? $signed(tri_fall) : $signed(tri_rise);
		endcase
	end

	assign product = $signed({{swo_pkg::LEVEL_W{wave[swo_pkg::SAMPLE_W-1]}}, wave})
		* $signed({{(swo_pkg::SAMPLE_W){1'b0}}, level});

endmodule
